FILE: src/lirn_pkg.sv
// Shared widths, defaults, opcodes and types for the nearest-neighbor remap block.
`timescale 1ns / 1ps

package lirn_pkg;

    localparam int IndexWidth = 19;
    localparam int CoordWidth = 16;
    localparam int RgbWidth   = 24;
    // Rounded magnitude of a coordinate: one bit for the absolute value of the most
    // negative code, one more for the added half.
    localparam int RoundWidth = CoordWidth + 2;

    localparam int DefFrameWidth    = 640;
    localparam int DefFrameHeight   = 480;
    localparam int DefCoordFracBits = 5;

    typedef enum logic [1:0] {
        OP_MAP_WRITE   = 2'd0,
        OP_PIXEL_WRITE = 2'd1,
        OP_EMIT        = 2'd2
    } opcode_t;

    // Result of rounding one coordinate and checking it against one frame bound.
    typedef struct packed {
        logic                  in_bounds;
        logic [RoundWidth-1:0] mag;
    } coord_res_t;

endpackage

FILE: src/lirn_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface lirn_in_if;
    import lirn_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [IndexWidth-1:0] pixel_index;
    logic [CoordWidth-1:0] coord_x;
    logic [CoordWidth-1:0] coord_y;
    logic [RgbWidth-1:0]   pixel_rgb;

    modport source (
        output valid, opcode, pixel_index, coord_x, coord_y, pixel_rgb,
        input  ready
    );

    modport sink (
        input  valid, opcode, pixel_index, coord_x, coord_y, pixel_rgb,
        output ready
    );
endinterface

interface lirn_out_if;
    import lirn_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [IndexWidth-1:0] out_index;
    logic [RgbWidth-1:0]   out_rgb;
    logic                  out_border;

    modport source (
        output valid, out_index, out_rgb, out_border,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_rgb, out_border,
        output ready
    );
endinterface

FILE: src/lut_image_remap_nearest.sv
// Top level of the nearest-neighbor image remap block: map table, source frame, pipeline.
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------------------
//   item     | in  | opcode, pixel_index, coord_x, coord_y, pixel_rgb
//   result   | out | out_index, out_rgb, out_border (one beat per emit only)
//
// One item is accepted per cycle while item.ready is high. An emit beat passes the input
// register, the map table read, then the source frame read that lands beside the output
// register, before it shows valid on result.
// Writes land in the map table or the source frame as they leave the input register.
// Reset clears only the pipeline valid bits; both memories are undefined until written.
// A stall on result backs up through the three stages; item.ready drops only when
// all of them hold an item.
`timescale 1ns / 1ps

module lut_image_remap_nearest #(
    parameter int FRAME_WIDTH     = lirn_pkg::DefFrameWidth,
    parameter int FRAME_HEIGHT    = lirn_pkg::DefFrameHeight,
    parameter int COORD_FRAC_BITS = lirn_pkg::DefCoordFracBits
) (
    input  logic       clk,
    input  logic       rst_n,
    lirn_in_if.sink    item,
    lirn_out_if.source result
);
    import lirn_pkg::*;

    localparam int Depth      = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AddrWidth  = $clog2(Depth);
    localparam int ColWidth   = $clog2(FRAME_WIDTH);
    localparam int RowWidth   = $clog2(FRAME_HEIGHT);
    localparam int ProdWidth  = ColWidth + RowWidth;
    localparam int EntryWidth = AddrWidth + 1;
    localparam int CmpWidth   = ((AddrWidth > IndexWidth) ? AddrWidth : IndexWidth) + 1;

    // Coordinate rounding ahead of the first register.
    coord_res_t x_res;
    coord_res_t y_res;

    lirn_coord_round #(
        .FracBits (COORD_FRAC_BITS),
        .Limit    (FRAME_WIDTH)
    ) u_round_x (
        .coord (item.coord_x),
        .res   (x_res)
    );

    lirn_coord_round #(
        .FracBits (COORD_FRAC_BITS),
        .Limit    (FRAME_HEIGHT)
    ) u_round_y (
        .coord (item.coord_y),
        .res   (y_res)
    );

    // Stage enables, from the output back to the input.
    logic en1;
    logic en2;
    logic en3;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic s3_valid_reg;
    logic s3_valid_next;

    logic [1:0]            s1_op_reg;
    logic [IndexWidth-1:0] s1_idx_reg;
    logic [ColWidth-1:0]   s1_col_reg;
    logic [RowWidth-1:0]   s1_row_reg;
    logic                  s1_inb_reg;
    logic [RgbWidth-1:0]   s1_rgb_reg;

    logic [IndexWidth-1:0] s2_idx_reg;
    logic                  s2_range_reg;

    logic [IndexWidth-1:0] s3_idx_reg;
    logic                  s3_border_reg;

    assign en3 = !s3_valid_reg || result.ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign item.ready = en1;

    // Stage 1: memory writes, and the map table read for an emit.
    logic                 s1_leave;
    logic                 s1_in_range;
    logic                 s1_emit;
    logic [ProdWidth-1:0] src_index;
    logic [AddrWidth-1:0] s1_addr;
    logic [EntryWidth-1:0] map_wr_data;
    logic                 map_wr_en;
    logic                 pix_wr_en;
    logic                 map_rd_en;
    logic [EntryWidth-1:0] map_rd_data;

    assign s1_leave    = s1_valid_reg && en2;
    assign s1_in_range = CmpWidth'(s1_idx_reg) < CmpWidth'(Depth);
    assign s1_emit     = (s1_op_reg == OP_EMIT);
    assign s1_addr     = AddrWidth'(s1_idx_reg);
    assign src_index   = ProdWidth'(s1_row_reg) * ProdWidth'(FRAME_WIDTH)
                       + ProdWidth'(s1_col_reg);
    // The top bit of an entry marks a source outside the frame.
    assign map_wr_data = {!s1_inb_reg, AddrWidth'(src_index)};

    // Writes leave stage 1 only together with the older emit ahead of them, so an
    // emit never sees a source pixel written by a younger item.
    assign map_wr_en = s1_leave && (s1_op_reg == OP_MAP_WRITE) && s1_in_range;
    assign pix_wr_en = s1_leave && (s1_op_reg == OP_PIXEL_WRITE) && s1_in_range;
    assign map_rd_en = s1_leave && s1_emit;

    lirn_ram #(
        .DataWidth (EntryWidth),
        .Depth     (Depth)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_wr_en),
        .wr_addr (s1_addr),
        .wr_data (map_wr_data),
        .rd_en   (map_rd_en),
        .rd_addr (s1_addr),
        .rd_data (map_rd_data)
    );

    // Stage 2: the map entry is back; read the source frame.
    logic                 s2_ok;
    logic                 frame_rd_en;
    logic [RgbWidth-1:0]  frame_rd_data;

    assign s2_ok       = s2_range_reg && !map_rd_data[AddrWidth];
    assign frame_rd_en = en3 && s2_valid_reg;

    lirn_ram #(
        .DataWidth (RgbWidth),
        .Depth     (Depth)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (s1_addr),
        .wr_data (s1_rgb_reg),
        .rd_en   (frame_rd_en),
        .rd_addr (map_rd_data[AddrWidth-1:0]),
        .rd_data (frame_rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        if (en1)
        begin
            s1_valid_next = item.valid;
        end
        if (en2)
        begin
            s2_valid_next = s1_valid_reg && s1_emit;
        end
        if (en3)
        begin
            s3_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg  <= item.opcode;
            s1_idx_reg <= item.pixel_index;
            s1_col_reg <= ColWidth'(x_res.mag);
            s1_row_reg <= RowWidth'(y_res.mag);
            s1_inb_reg <= x_res.in_bounds && y_res.in_bounds;
            s1_rgb_reg <= item.pixel_rgb;
        end
        if (en2)
        begin
            s2_idx_reg   <= s1_idx_reg;
            s2_range_reg <= s1_in_range;
        end
        if (en3)
        begin
            s3_idx_reg    <= s2_idx_reg;
            s3_border_reg <= !s2_ok;
        end
    end

    assign result.valid      = s3_valid_reg;
    assign result.out_index  = s3_idx_reg;
    assign result.out_border = s3_border_reg;
    assign result.out_rgb    = s3_border_reg ? '0 : frame_rd_data;

endmodule

FILE: src/lirn_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module lirn_ram #(
    parameter int DataWidth = 8,
    parameter int Depth     = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [DataWidth-1:0]     wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [DataWidth-1:0]     rd_data
);

    logic [DataWidth-1:0] mem [Depth];
    logic [DataWidth-1:0] rd_data_reg;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/lirn_coord_round.sv
// Rounds one fixed-point coordinate half away from zero and checks it against a bound.
`timescale 1ns / 1ps

module lirn_coord_round #(
    parameter int FracBits = lirn_pkg::DefCoordFracBits,
    parameter int Limit    = lirn_pkg::DefFrameWidth
) (
    input  logic [lirn_pkg::CoordWidth-1:0] coord,
    output lirn_pkg::coord_res_t            res
);
    import lirn_pkg::*;

    localparam int HalfInt = (FracBits > 0) ? (1 << (FracBits - 1)) : 0;

    logic                  neg;
    logic [CoordWidth:0]   mag;
    logic [RoundWidth-1:0] sum;
    logic [RoundWidth-1:0] rounded;

    assign neg = coord[CoordWidth-1];

    // Magnitude of the signed code; the most negative code needs the extra bit.
    assign mag = neg ? ((CoordWidth+1)'(0) - {coord[CoordWidth-1], coord})
                     : {1'b0, coord};

    assign sum     = {1'b0, mag} + RoundWidth'(HalfInt);
    assign rounded = sum >> FracBits;

    // A negative coordinate that rounds to zero is still inside the frame.
    assign res.mag       = rounded;
    assign res.in_bounds = !(neg && (rounded != '0)) && (rounded < RoundWidth'(Limit));

endmodule

FILE: src/lirn_checker.sv
// Port-level assertions for the remap block, bound to its top level.
`timescale 1ns / 1ps

module lirn_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [lirn_pkg::RgbWidth-1:0] out_rgb,
    input logic                          out_border
);

    // A pending result beat is not withdrawn.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped before it was taken");

    // A border pixel is always black.
    a_border_black: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_border |-> out_rgb == '0)
        else $error("border result carries a nonzero pixel");

    // The input side stalls only when the output side is stalled.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled without an output stall");

    // No result beat is shown while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind lut_image_remap_nearest lirn_checker u_lirn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_rgb      (result.out_rgb),
    .out_border   (result.out_border)
);

FILE: sim/lirn_remap_checker.sv
// Checker for the remap block: mirrors the map table and source frame and compares each result.
`timescale 1ns / 1ps

module lirn_remap_checker #(
    parameter int FRAME_WIDTH     = lirn_pkg::DefFrameWidth,
    parameter int FRAME_HEIGHT    = lirn_pkg::DefFrameHeight,
    parameter int COORD_FRAC_BITS = lirn_pkg::DefCoordFracBits
) (
    input  logic        clk,
    input  logic        rst_n,
    lirn_in_if          item,
    lirn_out_if         result,
    output int unsigned fail_count,
    output int unsigned pending_count,
    output int unsigned checked_count
);
    import lirn_pkg::*;

    localparam int FrameDepth = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int MaxReports = 40;

    typedef struct packed {
        logic        invalid;
        logic [19:0] source;
    } map_entry_t;

    typedef struct packed {
        logic [IndexWidth-1:0] index;
        logic [RgbWidth-1:0]   rgb;
        logic                  border;
    } remap_pixel_t;

    map_entry_t          map_entries [int];
    logic [RgbWidth-1:0] frame_pixels [int];
    remap_pixel_t        expected_pixels [$];
    int unsigned         mismatches;
    int unsigned         checked;

    assign fail_count    = mismatches;
    assign checked_count = checked;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MaxReports)
        begin
            $display("%0t ns: mismatch: %s", $realtime, msg);
        end
    endtask

    // Round half away from zero on the magnitude, then restore the sign.
    function automatic int round_coord(input logic [CoordWidth-1:0] raw);
        int mag;
        int half;
        int rounded;
        mag     = raw[CoordWidth-1] ? (1 << CoordWidth) - int'(raw) : int'(raw);
        half    = (COORD_FRAC_BITS > 0) ? (1 << (COORD_FRAC_BITS - 1)) : 0;
        rounded = (mag + half) >> COORD_FRAC_BITS;
        return raw[CoordWidth-1] ? -rounded : rounded;
    endfunction

    task automatic predict_remap();
        int           idx;
        int           x;
        int           y;
        map_entry_t   entry;
        remap_pixel_t pix;
        idx = int'(item.pixel_index);
        case (item.opcode)
            OP_MAP_WRITE:
            begin
                x = round_coord(item.coord_x);
                y = round_coord(item.coord_y);
                if (idx < FrameDepth)
                begin
                    if (x < 0 || x >= FRAME_WIDTH || y < 0 || y >= FRAME_HEIGHT)
                    begin
                        entry = '{invalid: 1'b1, source: '0};
                    end
                    else
                    begin
                        entry = '{invalid: 1'b0, source: 20'(y * FRAME_WIDTH + x)};
                    end
                    map_entries[idx] = entry;
                end
            end
            OP_PIXEL_WRITE:
            begin
                if (idx < FrameDepth)
                begin
                    frame_pixels[idx] = item.pixel_rgb;
                end
            end
            OP_EMIT:
            begin
                pix.index  = item.pixel_index;
                pix.rgb    = '0;
                pix.border = 1'b1;
                if (idx < FrameDepth)
                begin
                    entry = map_entries.exists(idx) ? map_entries[idx] : '0;
                    if (!entry.invalid && int'(entry.source) < FrameDepth)
                    begin
                        pix.rgb = frame_pixels.exists(int'(entry.source))
                                ? frame_pixels[int'(entry.source)] : '0;
                        pix.border = 1'b0;
                    end
                end
                expected_pixels.push_back(pix);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        remap_pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing expected, index %0d",
                                      result.out_index));
            return;
        end
        want = expected_pixels.pop_front();
        checked++;
        if (result.out_index !== want.index)
        begin
            report_mismatch($sformatf("out_index %0d, expected %0d",
                                      result.out_index, want.index));
        end
        if (result.out_rgb !== want.rgb)
        begin
            report_mismatch($sformatf("index %0d: out_rgb %06h, expected %06h",
                                      want.index, result.out_rgb, want.rgb));
        end
        if (result.out_border !== want.border)
        begin
            report_mismatch($sformatf("index %0d: out_border %b, expected %b",
                                      want.index, result.out_border, want.border));
        end
    endtask

    // Results are checked before the new beat is predicted; an emit passes through registered
    // stages, so a beat can never answer an item accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                check_result();
            end
            if (item.valid && item.ready)
            begin
                predict_remap();
            end
            pending_count <= expected_pixels.size();
        end
    end

endmodule

FILE: sim/lut_image_remap_nearest_tb.sv
// Testbench top for the remap block: reset, stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module lut_image_remap_nearest_tb;
    import lirn_pkg::*;

    localparam int FrameWidth  = DefFrameWidth;
    localparam int FrameHeight = DefFrameHeight;
    localparam int FrameDepth  = FrameWidth * FrameHeight;
    localparam int IndexMax    = (1 << IndexWidth) - 1;
    localparam int CoordScale  = 1 << DefCoordFracBits;
    localparam int CoordHalf   = (DefCoordFracBits > 0) ? CoordScale / 2 : 0;
    localparam int CoordMax    = (1 << (CoordWidth - 1)) - 1;
    localparam int CoordMin    = -(1 << (CoordWidth - 1));
    localparam int ItemTarget  = 1250;
    localparam int StallLimit  = 2000;
    localparam int TailCycles  = 8;

    localparam logic [1:0] OpUnused = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned tx_idle_pct = 22;
    int unsigned rx_idle_pct = 81;
    int unsigned idle_cycles;
    int unsigned sent_items;
    int unsigned map_writes;
    int unsigned pixel_writes;
    int unsigned emits;
    int unsigned far_emits;
    int unsigned ignored_items;

    // Which source pixels and map entries are safe to read back.
    bit pixel_written [int];
    int written_pixels [$];
    bit map_usable [int];
    int usable_maps [$];
    int hot_indexes [$];

    lirn_in_if  item();
    lirn_out_if result();

    lut_image_remap_nearest DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    lirn_remap_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        result.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item.valid && item.ready) || (result.valid && result.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= StallLimit)
            begin
                $display("Timeout: no beat moved for %0d cycles", StallLimit);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [CoordWidth-1:0] coord_code(input int target, input int frac);
        int raw;
        raw = target * CoordScale + frac;
        if (raw > CoordMax)
        begin
            raw = CoordMax;
        end
        if (raw < CoordMin)
        begin
            raw = CoordMin;
        end
        return CoordWidth'(raw);
    endfunction

    // Fraction offsets that still round to the target, half away from zero.
    function automatic int random_frac(input int target);
        int lo;
        int hi;
        lo = (target > 0) ? -CoordHalf : -(CoordScale - CoordHalf - 1);
        hi = (target < 0) ? CoordHalf : CoordScale - CoordHalf - 1;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int pick_index();
        if ($urandom_range(1) == 0)
        begin
            return hot_indexes[$urandom_range(hot_indexes.size() - 1)];
        end
        return int'($urandom_range(FrameDepth - 1));
    endfunction

    function automatic int far_index();
        return FrameDepth + int'($urandom_range(IndexMax - FrameDepth));
    endfunction

    task automatic send_item(input logic [1:0] op, input int idx,
                             input logic [CoordWidth-1:0] cx, input logic [CoordWidth-1:0] cy,
                             input logic [RgbWidth-1:0] rgb);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            item.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < tx_idle_pct);
        end
        item.valid       <= 1'b1;
        item.opcode      <= op;
        item.pixel_index <= IndexWidth'(idx);
        item.coord_x     <= cx;
        item.coord_y     <= cy;
        item.pixel_rgb   <= rgb;
        @(posedge clk);
        while (!item.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_pixel(input int idx, input logic [RgbWidth-1:0] rgb);
        send_item(OP_PIXEL_WRITE, idx, CoordWidth'($urandom), CoordWidth'($urandom), rgb);
        if (idx >= FrameDepth)
        begin
            ignored_items++;
        end
        else
        begin
            pixel_writes++;
            sent_items++;
            if (!pixel_written.exists(idx))
            begin
                pixel_written[idx] = 1'b1;
                written_pixels.push_back(idx);
            end
        end
    endtask

    // A scrambled write uses raw random coordinates, so its entry is never read back.
    task automatic map_to(input int idx, input int tx, input int ty,
                          input int fx, input int fy, input bit scrambled);
        logic [CoordWidth-1:0] cx;
        logic [CoordWidth-1:0] cy;
        cx = scrambled ? CoordWidth'($urandom) : coord_code(tx, fx);
        cy = scrambled ? CoordWidth'($urandom) : coord_code(ty, fy);
        send_item(OP_MAP_WRITE, idx, cx, cy, RgbWidth'($urandom));
        if (idx >= FrameDepth)
        begin
            ignored_items++;
        end
        else
        begin
            map_writes++;
            sent_items++;
            if (scrambled)
            begin
                map_usable[idx] = 1'b0;
            end
            else if (!map_usable.exists(idx) || !map_usable[idx])
            begin
                map_usable[idx] = 1'b1;
                usable_maps.push_back(idx);
            end
        end
    endtask

    task automatic emit_pixel(input int idx);
        send_item(OP_EMIT, idx, CoordWidth'($urandom), CoordWidth'($urandom),
                  RgbWidth'($urandom));
        emits++;
        sent_items++;
        if (idx >= FrameDepth)
        begin
            far_emits++;
        end
    endtask

    task automatic drain_results();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int          idx;
        int          pick;
        int          tx;
        int          ty;
        int          p;
        int          phase_end;
        int unsigned roll;
        int unsigned sel;

        rst_n            <= 1'b0;
        item.valid       <= 1'b0;
        item.opcode      <= '0;
        item.pixel_index <= '0;
        item.coord_x     <= '0;
        item.coord_y     <= '0;
        item.pixel_rgb   <= '0;

        hot_indexes = '{0, FrameWidth - 1, FrameDepth - FrameWidth, FrameDepth - 1};
        repeat (60)
        begin
            hot_indexes.push_back(int'($urandom_range(FrameDepth - 1)));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the four frame corners, rounding at both edges of each axis,
        // the extreme coordinate codes, indexes past the frame and the unused opcode.
        write_pixel(0, 24'hFFFFFF);
        write_pixel(FrameWidth - 1, 24'h123456);
        write_pixel(FrameDepth - FrameWidth, 24'h800001);
        write_pixel(FrameDepth - 1, 24'h7FFFFE);
        map_to(0, 0, 0, -(CoordScale - CoordHalf - 1), CoordScale - CoordHalf - 1, 1'b0);
        emit_pixel(0);
        map_to(1, FrameWidth - 1, 0, CoordScale - CoordHalf - 1, 0, 1'b0);
        emit_pixel(1);
        map_to(2, FrameWidth, 0, -CoordHalf, 0, 1'b0);
        emit_pixel(2);
        map_to(3, -1, 0, CoordHalf, 0, 1'b0);
        emit_pixel(3);
        map_to(4, 0, FrameHeight - 1, 0, CoordScale - CoordHalf - 1, 1'b0);
        emit_pixel(4);
        map_to(5, 0, FrameHeight, 0, -CoordHalf, 1'b0);
        emit_pixel(5);
        map_to(FrameDepth - 1, 1024, -1024, CoordScale - CoordHalf - 1, 0, 1'b0);
        emit_pixel(FrameDepth - 1);
        map_to(FrameDepth - 2, FrameWidth - 1, FrameHeight - 1, -CoordHalf, -CoordHalf, 1'b0);
        emit_pixel(FrameDepth - 2);
        emit_pixel(FrameDepth);
        emit_pixel(IndexMax);
        map_to(IndexMax, 0, 0, 0, 0, 1'b0);
        write_pixel(FrameDepth, 24'hABCDEF);
        send_item(OpUnused, 0, '0, '0, '0);
        ignored_items++;
        write_pixel(0, 24'h000000);
        emit_pixel(0);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 81 : 0;
            rx_idle_pct <= (phase == 0) ? 81 : (phase == 1) ? 22 : 0;
            phase_end = ItemTarget * (phase + 1) / 3;
            while (sent_items < phase_end)
            begin
                roll = $urandom_range(99);
                if (roll < 5)
                begin
                    send_item(OpUnused, int'($urandom_range(IndexMax)), CoordWidth'($urandom),
                              CoordWidth'($urandom), RgbWidth'($urandom));
                    ignored_items++;
                end
                else if (roll < 30)
                begin
                    idx = ($urandom_range(19) == 0) ? far_index() : pick_index();
                    write_pixel(idx, RgbWidth'($urandom));
                end
                else if (roll < 60)
                begin
                    idx = ($urandom_range(19) == 0) ? far_index() : pick_index();
                    sel = $urandom_range(99);
                    if (sel < 15)
                    begin
                        map_to(idx, 0, 0, 0, 0, 1'b1);
                    end
                    else if (sel < 75 && written_pixels.size() > 0)
                    begin
                        p  = written_pixels[$urandom_range(written_pixels.size() - 1)];
                        tx = p % FrameWidth;
                        ty = p / FrameWidth;
                        map_to(idx, tx, ty, random_frac(tx), random_frac(ty), 1'b0);
                    end
                    else
                    begin
                        tx = int'($urandom_range(2048)) - 1024;
                        ty = int'($urandom_range(2048)) - 1024;
                        if (tx >= 0 && tx < FrameWidth && ty >= 0 && ty < FrameHeight)
                        begin
                            if ($urandom_range(1) == 0)
                            begin
                                tx = -1 - int'($urandom_range(1023));
                            end
                            else
                            begin
                                ty = FrameHeight + int'($urandom_range(1024 - FrameHeight));
                            end
                        end
                        map_to(idx, tx, ty, random_frac(tx), random_frac(ty), 1'b0);
                    end
                end
                else
                begin
                    // Emit only where the entry and the pixel behind it were written.
                    idx = far_index();
                    if (usable_maps.size() > 0 && $urandom_range(9) != 0)
                    begin
                        for (int t = 0; t < 4; t++)
                        begin
                            pick = usable_maps[$urandom_range(usable_maps.size() - 1)];
                            if (map_usable[pick])
                            begin
                                idx = pick;
                                break;
                            end
                        end
                    end
                    emit_pixel(idx);
                end
            end
            drain_results();
        end

        repeat (TailCycles) @(posedge clk);
        $display("Covered %0d map writes, %0d pixel writes, %0d emits (%0d past the frame)",
                 map_writes, pixel_writes, emits, far_emits);
        $display("and %0d ignored items; %0d result beats compared under three stall mixes.",
                 ignored_items, checked_count);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
